[hdl/lj_pkg.sv]
// Package for the Lennard-Jones pair force block: sizes, codes, state types,
// and the Q24.24 saturation helper. No dependencies.
`default_nettype none

package lj_pkg;

   // Epsilon table capacity
   localparam int MAX_TYPES   = 16;
   localparam int TABLE_DEPTH = MAX_TYPES * MAX_TYPES;
   localparam int TBL_IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // Field widths
   localparam int TYPE_W     = 9;
   localparam int RAD_W      = 24;
   localparam int POS_W      = 32;
   localparam int EPS_W      = 24;
   localparam int EPSV_W     = 25;
   localparam int RES_W      = 48;
   localparam int STAT_W     = 2;
   localparam int REQ_DATA_W = 288;
   localparam int RSP_DATA_W = 216;

   // Arithmetic constants
   localparam logic [31:0]  INV_CBRT2_Q32     = 32'd3408917802;
   localparam logic [23:0]  DEFAULT_EPS_RESET = 24'd65536;
   localparam logic [127:0] ROUND32           = 128'h8000_0000;
   localparam logic [127:0] ROUND24           = 128'h80_0000;
   localparam logic [127:0] MAG_BIG           = {64'd1, 64'd0};
   localparam logic [47:0]  RES_MAX           = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0]  RES_MIN_MAG       = 48'h8000_0000_0000;
   localparam logic [7:0]   DIV_Q_STEPS       = 8'd82;
   localparam logic [7:0]   DIV_F_STEPS       = 8'd128;

   typedef enum logic {
      CMD_COMPUTE = 1'b0,
      CMD_SET     = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_REJECT = 2'd1,
      STAT_BEYOND = 2'd2,
      STAT_ZERO   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SET_AB,
      ST_SET_BA,
      ST_DIFF,
      ST_LOAD,
      ST_MUL,
      ST_DIV,
      ST_POST,
      ST_OUT
   } state_type;

   // Steps of the arithmetic sequence
   typedef enum logic [3:0] {
      STEP_RX,
      STEP_RY,
      STEP_RZ,
      STEP_SS,
      STEP_SIG,
      STEP_Q,
      STEP_Q2,
      STEP_Q3,
      STEP_Q6,
      STEP_POT,
      STEP_G,
      STEP_N,
      STEP_F
   } step_type;

   // Signed saturation of a magnitude to Q24.24
   function automatic logic [47:0] sat48(input logic [127:0] mag, input logic neg);
      logic        big;
      logic [47:0] m;
      big = (|mag[127:48]) || (mag[47] && ((|mag[46:0]) || !neg));
      m   = big ? (neg ? RES_MIN_MAG : RES_MAX) : mag[47:0];
      return neg ? (48'd0 - m) : m;
   endfunction

endpackage

`default_nettype wire

[hdl/lj_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lj_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[hdl/lennard_jones_pair_force.sv]
// Lennard-Jones 12-6 pair potential and force, one shared adder sequenced
// through shift-add multiplies and restoring divides. Uses lj_pkg, lj_ram.
//
// A set item passes through ST_SET_AB and ST_SET_BA before it offers its result, and
// through ST_SET_AB alone when it is rejected. In a compute item each multiply
// runs one adder pass per multiplier bit up to its highest set bit, each divide one per quotient
// bit (82 for the ratio, 128 for each force component); the shared 128-bit adder sets the pace.
// One item at a time; req_tready is high only when no item is in flight.
// Synchronous reset clears the written flags and restores default_epsilon.
`default_nettype none

module lennard_jones_pair_force (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // type_a[8:0], type_b[17:9], radius_a[41:18], radius_b[65:42],
   // pos_a_x/y/z[161:66], pos_b_x/y/z[257:162], epsilon_value[282:258]
   input  wire logic [lj_pkg::REQ_DATA_W-1:0] req_tdata,
   // command[0]
   input  wire logic                          req_tuser,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // epsilon_used[23:0], potential[71:24], force_x[119:72],
   // force_y[167:120], force_z[215:168]
   output logic      [lj_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic      [lj_pkg::STAT_W-1:0]     rsp_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   input  wire logic [lj_pkg::EPS_W-1:0]      csr_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready
);

   // Control registers
   lj_pkg::state_type             state_ff, state_in;
   lj_pkg::step_type              step_ff, step_in;
   logic [1:0]                    axis_ff, axis_in;
   logic [lj_pkg::TABLE_DEPTH-1:0] written_ff, written_in;
   logic [lj_pkg::EPS_W-1:0]      dflt_eps_ff, dflt_eps_in;

   // Latched item
   lj_pkg::cmd_type               cmd_ff, cmd_in;
   logic [lj_pkg::TYPE_W-1:0]     type_a_ff, type_a_in, type_b_ff, type_b_in;
   logic [lj_pkg::RAD_W-1:0]      rad_a_ff, rad_a_in, rad_b_ff, rad_b_in;
   logic [lj_pkg::POS_W-1:0]      pos_a_ff [3];
   logic [lj_pkg::POS_W-1:0]      pos_a_in [3];
   logic [lj_pkg::POS_W-1:0]      pos_b_ff [3];
   logic [lj_pkg::POS_W-1:0]      pos_b_in [3];
   logic [lj_pkg::EPSV_W-1:0]     epsv_ff, epsv_in;

   // Intermediate values
   logic                          d_neg_ff [3];
   logic                          d_neg_in [3];
   logic [32:0]                   ud_ff [3];
   logic [32:0]                   ud_in [3];
   logic [65:0]                   rsq_ff, rsq_in;
   logic [41:0]                   q_ff, q_in;
   logic [51:0]                   q2_ff, q2_in;
   logic [61:0]                   q3_ff, q3_in;
   logic [91:0]                   q6_ff, q6_in;
   logic                          pneg_ff, pneg_in, fneg_ff, fneg_in;
   logic [121:0]                  gm_ff, gm_in;

   // Result registers
   lj_pkg::status_type            status_ff, status_in;
   logic [lj_pkg::EPS_W-1:0]      eps_ff, eps_in;
   logic [lj_pkg::RES_W-1:0]      pot_ff, pot_in;
   logic [lj_pkg::RES_W-1:0]      frc_ff [3];
   logic [lj_pkg::RES_W-1:0]      frc_in [3];

   // Shared arithmetic unit
   logic [127:0]                  acc_ff, acc_in, mcand_ff, mcand_in, num_ff, num_in;
   logic [61:0]                   mplier_ff, mplier_in;
   logic [7:0]                    cnt_ff, cnt_in;
   logic                          ovf_ff, ovf_in;
   logic [127:0]                  add_a;
   logic                          add_sub;
   logic [128:0]                  add_sum;

   // Table access
   logic                          ram_we;
   logic [lj_pkg::TBL_IDX_W-1:0]  idx_ab, idx_ba, ram_wr_addr;
   logic [lj_pkg::EPS_W-1:0]      ram_rd_data;
   logic [15:0]                   idx_ab_wide, idx_ba_wide;
   logic                          ta_neg, tb_neg, ta_lt, tb_lt, beyond, use_tbl;

   // Misc combinational values
   logic [32:0]                   dk;
   logic [24:0]                   rad_sum;
   logic [92:0]                   q3_e, q6_e, two6;
   logic [28:0]                   eps24;
   logic                          neg_k, axis_last;

   // Type decode and table index
   assign ta_neg      = type_a_ff[8];
   assign tb_neg      = type_b_ff[8];
   assign ta_lt       = type_a_ff < 9'(lj_pkg::MAX_TYPES);
   assign tb_lt       = type_b_ff < 9'(lj_pkg::MAX_TYPES);
   assign beyond      = (!ta_neg && !ta_lt) || (!tb_neg && !tb_lt);
   assign idx_ab_wide = 16'(type_a_ff[7:0]) * 16'(lj_pkg::MAX_TYPES) + 16'(type_b_ff[7:0]);
   assign idx_ba_wide = 16'(type_b_ff[7:0]) * 16'(lj_pkg::MAX_TYPES) + 16'(type_a_ff[7:0]);
   assign idx_ab      = idx_ab_wide[lj_pkg::TBL_IDX_W-1:0];
   assign idx_ba      = idx_ba_wide[lj_pkg::TBL_IDX_W-1:0];
   assign use_tbl     = ta_lt && tb_lt && written_ff[idx_ab];
   assign ram_wr_addr = (state_ff == lj_pkg::ST_SET_BA) ? idx_ba : idx_ab;

   lj_ram #(
      .WIDTH (lj_pkg::EPS_W),
      .DEPTH (lj_pkg::TABLE_DEPTH)
   ) u_eps_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (epsv_ff[lj_pkg::EPS_W-1:0]),
      .rd_addr (idx_ab),
      .rd_data (ram_rd_data)
   );

   // Shared adder: accumulate for multiply, trial subtract for divide
   assign add_sub = (state_ff == lj_pkg::ST_DIV);
   assign add_a   = add_sub ? {acc_ff[126:0], num_ff[127]} : acc_ff;
   assign add_sum = {1'b0, add_a} + {1'b0, add_sub ? ~mcand_ff : mcand_ff} + 129'(add_sub);

   assign rad_sum   = 25'(rad_a_ff) + 25'(rad_b_ff);
   assign q3_e      = 93'(q3_ff);
   assign q6_e      = 93'(q6_ff);
   assign two6      = {q6_ff, 1'b0};
   assign eps24     = 29'({eps_ff, 4'd0}) + 29'({eps_ff, 3'd0});
   assign neg_k     = d_neg_ff[axis_ff] ^ fneg_ff;
   assign axis_last = (axis_ff == 2'd2);

   // Handshakes
   assign req_tready = (state_ff == lj_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == lj_pkg::ST_OUT);
   assign csr_ready  = 1'b1;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {frc_ff[2], frc_ff[1], frc_ff[0], pot_ff, eps_ff};

   // Sequencer and datapath next state
   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      axis_in     = axis_ff;
      written_in  = written_ff;
      dflt_eps_in = csr_valid ? csr_data : dflt_eps_ff;
      cmd_in      = cmd_ff;
      type_a_in   = type_a_ff;
      type_b_in   = type_b_ff;
      rad_a_in    = rad_a_ff;
      rad_b_in    = rad_b_ff;
      epsv_in     = epsv_ff;
      rsq_in      = rsq_ff;
      q_in        = q_ff;
      q2_in       = q2_ff;
      q3_in       = q3_ff;
      q6_in       = q6_ff;
      pneg_in     = pneg_ff;
      fneg_in     = fneg_ff;
      gm_in       = gm_ff;
      status_in   = status_ff;
      eps_in      = eps_ff;
      pot_in      = pot_ff;
      acc_in      = acc_ff;
      mcand_in    = mcand_ff;
      num_in      = num_ff;
      mplier_in   = mplier_ff;
      cnt_in      = cnt_ff;
      ovf_in      = ovf_ff;
      ram_we      = 1'b0;
      dk          = '0;
      for (int k = 0; k < 3; k++) begin
         pos_a_in[k] = pos_a_ff[k];
         pos_b_in[k] = pos_b_ff[k];
         d_neg_in[k] = d_neg_ff[k];
         ud_in[k]    = ud_ff[k];
         frc_in[k]   = frc_ff[k];
      end

      unique case (state_ff)
         lj_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in    = lj_pkg::cmd_type'(req_tuser);
               type_a_in = req_tdata[8:0];
               type_b_in = req_tdata[17:9];
               rad_a_in  = req_tdata[41:18];
               rad_b_in  = req_tdata[65:42];
               for (int k = 0; k < 3; k++) begin
                  pos_a_in[k] = req_tdata[66 + 32*k +: 32];
                  pos_b_in[k] = req_tdata[162 + 32*k +: 32];
               end
               epsv_in  = req_tdata[282:258];
               state_in = req_tuser ? lj_pkg::ST_SET_AB : lj_pkg::ST_DIFF;
            end
         end

         // Table write, first of the mirrored pair; rejected or out-of-range items go to ST_OUT
         lj_pkg::ST_SET_AB: begin
            pot_in = '0;
            for (int k = 0; k < 3; k++) begin
               frc_in[k] = '0;
            end
            if (ta_neg || tb_neg || epsv_ff[lj_pkg::EPSV_W-1]) begin
               status_in = lj_pkg::STAT_REJECT;
               eps_in    = '0;
               state_in  = lj_pkg::ST_OUT;
            end else if (beyond) begin
               status_in = lj_pkg::STAT_BEYOND;
               eps_in    = '0;
               state_in  = lj_pkg::ST_OUT;
            end else begin
               ram_we             = 1'b1;
               written_in[idx_ab] = 1'b1;
               written_in[idx_ba] = 1'b1;
               status_in          = lj_pkg::STAT_OK;
               eps_in             = epsv_ff[lj_pkg::EPS_W-1:0];
               state_in           = lj_pkg::ST_SET_BA;
            end
         end

         lj_pkg::ST_SET_BA: begin
            ram_we   = 1'b1;
            state_in = lj_pkg::ST_OUT;
         end

         // Displacement, magnitudes and signs
         lj_pkg::ST_DIFF: begin
            for (int k = 0; k < 3; k++) begin
               dk          = {pos_b_ff[k][31], pos_b_ff[k]} - {pos_a_ff[k][31], pos_a_ff[k]};
               d_neg_in[k] = dk[32];
               ud_in[k]    = dk[32] ? (33'd0 - dk) : dk;
               frc_in[k]   = '0;
            end
            pot_in    = '0;
            status_in = beyond ? lj_pkg::STAT_BEYOND : lj_pkg::STAT_OK;
            acc_in    = '0;
            step_in   = lj_pkg::STEP_RX;
            state_in  = lj_pkg::ST_LOAD;
         end

         // Operand setup for the next multiply or divide
         lj_pkg::ST_LOAD: begin
            state_in = lj_pkg::ST_MUL;
            unique case (step_ff)
               lj_pkg::STEP_RX: begin
                  eps_in    = use_tbl ? ram_rd_data : dflt_eps_ff;
                  mcand_in  = 128'(ud_ff[0]);
                  mplier_in = 62'(ud_ff[0]);
               end
               lj_pkg::STEP_RY: begin
                  mcand_in  = 128'(ud_ff[1]);
                  mplier_in = 62'(ud_ff[1]);
               end
               lj_pkg::STEP_RZ: begin
                  mcand_in  = 128'(ud_ff[2]);
                  mplier_in = 62'(ud_ff[2]);
               end
               lj_pkg::STEP_SS: begin
                  acc_in    = '0;
                  mcand_in  = 128'(rad_sum);
                  mplier_in = 62'(rad_sum);
               end
               lj_pkg::STEP_SIG: begin
                  acc_in    = lj_pkg::ROUND32;
                  mcand_in  = 128'(acc_ff[49:0]);
                  mplier_in = 62'(lj_pkg::INV_CBRT2_Q32);
               end
               lj_pkg::STEP_Q: begin
                  num_in   = {acc_ff[81:32], 78'd0};
                  acc_in   = '0;
                  mcand_in = 128'(rsq_ff);
                  cnt_in   = lj_pkg::DIV_Q_STEPS;
                  state_in = lj_pkg::ST_DIV;
               end
               lj_pkg::STEP_Q2: begin
                  acc_in    = lj_pkg::ROUND32;
                  mcand_in  = 128'(q_ff);
                  mplier_in = 62'(q_ff);
               end
               lj_pkg::STEP_Q3: begin
                  acc_in    = lj_pkg::ROUND32;
                  mcand_in  = 128'(q2_ff);
                  mplier_in = 62'(q_ff);
               end
               lj_pkg::STEP_Q6: begin
                  acc_in    = lj_pkg::ROUND32;
                  mcand_in  = 128'(q3_ff);
                  mplier_in = q3_ff;
               end
               lj_pkg::STEP_POT: begin
                  acc_in    = lj_pkg::ROUND24;
                  mcand_in  = 128'(pneg_ff ? (q3_e - q6_e) : (q6_e - q3_e));
                  mplier_in = 62'({eps_ff, 2'd0});
               end
               lj_pkg::STEP_G: begin
                  fneg_in   = q3_e < two6;
                  acc_in    = '0;
                  mcand_in  = 128'((q3_e < two6) ? (two6 - q3_e) : (q3_e - two6));
                  mplier_in = 62'(eps24);
               end
               lj_pkg::STEP_N: begin
                  if (ud_ff[axis_ff] == '0) begin
                     frc_in[axis_ff] = '0;
                     if (axis_last) begin
                        state_in = lj_pkg::ST_OUT;
                     end else begin
                        axis_in  = axis_ff + 2'd1;
                        state_in = lj_pkg::ST_LOAD;
                     end
                  end else begin
                     acc_in    = '0;
                     ovf_in    = 1'b0;
                     mcand_in  = 128'(gm_ff);
                     mplier_in = 62'(ud_ff[axis_ff]);
                  end
               end
               lj_pkg::STEP_F: begin
                  num_in   = acc_ff + (128'(rsq_ff) << 7);
                  acc_in   = '0;
                  mcand_in = 128'(rsq_ff) << 8;
                  cnt_in   = lj_pkg::DIV_F_STEPS;
                  state_in = lj_pkg::ST_DIV;
               end
               default: begin
                  state_in = lj_pkg::ST_IDLE;
               end
            endcase
         end

         // Shift-add multiply, one multiplier bit a cycle
         lj_pkg::ST_MUL: begin
            if (mplier_ff == '0) begin
               state_in = lj_pkg::ST_POST;
            end else begin
               if (mplier_ff[0]) begin
                  acc_in = add_sum[127:0];
                  ovf_in = ovf_ff | add_sum[128];
               end
               if (mcand_ff[127] && (|mplier_ff[61:1])) begin
                  ovf_in = 1'b1;
               end
               mcand_in  = {mcand_ff[126:0], 1'b0};
               mplier_in = {1'b0, mplier_ff[61:1]};
            end
         end

         // Restoring divide, one quotient bit a cycle
         lj_pkg::ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = lj_pkg::ST_POST;
            end else begin
               acc_in = add_sum[128] ? add_sum[127:0] : add_a;
               num_in = {num_ff[126:0], add_sum[128]};
               cnt_in = cnt_ff - 8'd1;
            end
         end

         // Take the unit's result
         lj_pkg::ST_POST: begin
            state_in = lj_pkg::ST_LOAD;
            unique case (step_ff)
               lj_pkg::STEP_RX: begin
                  step_in = lj_pkg::STEP_RY;
               end
               lj_pkg::STEP_RY: begin
                  step_in = lj_pkg::STEP_RZ;
               end
               lj_pkg::STEP_RZ: begin
                  rsq_in = acc_ff[65:0];
                  if (acc_ff[65:0] == '0) begin
                     status_in = lj_pkg::STAT_ZERO;
                     pot_in    = lj_pkg::RES_MAX;
                     state_in  = lj_pkg::ST_OUT;
                  end else begin
                     step_in = lj_pkg::STEP_SS;
                  end
               end
               lj_pkg::STEP_SS: begin
                  step_in = lj_pkg::STEP_SIG;
               end
               lj_pkg::STEP_SIG: begin
                  step_in = lj_pkg::STEP_Q;
               end
               lj_pkg::STEP_Q: begin
                  if (|num_ff[81:42]) begin
                     // ratio too large: every nonzero result saturates
                     if (eps_ff != '0) begin
                        pot_in = lj_pkg::RES_MAX;
                        for (int k = 0; k < 3; k++) begin
                           frc_in[k] = (ud_ff[k] != '0) ?
                              lj_pkg::sat48(lj_pkg::MAG_BIG, !d_neg_ff[k]) : '0;
                        end
                     end
                     state_in = lj_pkg::ST_OUT;
                  end else begin
                     q_in    = num_ff[41:0];
                     step_in = lj_pkg::STEP_Q2;
                  end
               end
               lj_pkg::STEP_Q2: begin
                  q2_in   = acc_ff[83:32];
                  step_in = lj_pkg::STEP_Q3;
               end
               lj_pkg::STEP_Q3: begin
                  q3_in   = acc_ff[93:32];
                  step_in = lj_pkg::STEP_Q6;
               end
               lj_pkg::STEP_Q6: begin
                  q6_in   = acc_ff[123:32];
                  pneg_in = acc_ff[123:32] < 92'(q3_ff);
                  step_in = lj_pkg::STEP_POT;
               end
               lj_pkg::STEP_POT: begin
                  pot_in  = lj_pkg::sat48({24'd0, acc_ff[127:24]}, pneg_ff);
                  step_in = lj_pkg::STEP_G;
               end
               lj_pkg::STEP_G: begin
                  gm_in   = acc_ff[121:0];
                  axis_in = 2'd0;
                  step_in = lj_pkg::STEP_N;
               end
               lj_pkg::STEP_N: begin
                  if (ovf_ff || acc_ff[127]) begin
                     frc_in[axis_ff] = lj_pkg::sat48(lj_pkg::MAG_BIG, neg_k);
                     if (axis_last) begin
                        state_in = lj_pkg::ST_OUT;
                     end else begin
                        axis_in = axis_ff + 2'd1;
                     end
                  end else begin
                     step_in = lj_pkg::STEP_F;
                  end
               end
               lj_pkg::STEP_F: begin
                  frc_in[axis_ff] = lj_pkg::sat48(num_ff, neg_k);
                  step_in         = lj_pkg::STEP_N;
                  if (axis_last) begin
                     state_in = lj_pkg::ST_OUT;
                  end else begin
                     axis_in = axis_ff + 2'd1;
                  end
               end
               default: begin
                  state_in = lj_pkg::ST_IDLE;
               end
            endcase
         end

         lj_pkg::ST_OUT: begin
            if (rsp_tready) begin
               state_in = lj_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lj_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lj_pkg::ST_IDLE;
         step_ff     <= lj_pkg::STEP_RX;
         axis_ff     <= 2'd0;
         written_ff  <= '0;
         dflt_eps_ff <= lj_pkg::DEFAULT_EPS_RESET;
      end else begin
         state_ff    <= state_in;
         step_ff     <= step_in;
         axis_ff     <= axis_in;
         written_ff  <= written_in;
         dflt_eps_ff <= dflt_eps_in;
      end
   end

   // Payload and datapath
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      type_a_ff <= type_a_in;
      type_b_ff <= type_b_in;
      rad_a_ff  <= rad_a_in;
      rad_b_ff  <= rad_b_in;
      epsv_ff   <= epsv_in;
      rsq_ff    <= rsq_in;
      q_ff      <= q_in;
      q2_ff     <= q2_in;
      q3_ff     <= q3_in;
      q6_ff     <= q6_in;
      pneg_ff   <= pneg_in;
      fneg_ff   <= fneg_in;
      gm_ff     <= gm_in;
      status_ff <= status_in;
      eps_ff    <= eps_in;
      pot_ff    <= pot_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      num_ff    <= num_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
      ovf_ff    <= ovf_in;
      for (int k = 0; k < 3; k++) begin
         pos_a_ff[k] <= pos_a_in[k];
         pos_b_ff[k] <= pos_b_in[k];
         d_neg_ff[k] <= d_neg_in[k];
         ud_ff[k]    <= ud_in[k];
         frc_ff[k]   <= frc_in[k];
      end
   end

   // Never taking a new item while a result is offered
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted while result pending");

   // Written flags only change on an accepted table write
   assert property (@(posedge clock) disable iff (reset)
      (written_ff != $past(written_ff)) |-> ($past(state_ff) == lj_pkg::ST_SET_AB))
      else $error("written flag changed outside a set item");

   // Zero distance gives maximum potential and no force
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && status_ff == lj_pkg::STAT_ZERO) |->
      (pot_ff == lj_pkg::RES_MAX && frc_ff[0] == '0 && frc_ff[1] == '0 && frc_ff[2] == '0))
      else $error("zero distance result malformed");

   // Set results carry no potential or force
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && cmd_ff == lj_pkg::CMD_SET) |->
      (pot_ff == '0 && frc_ff[0] == '0 && frc_ff[1] == '0 && frc_ff[2] == '0
       && (status_ff == lj_pkg::STAT_OK || eps_ff == '0)))
      else $error("set result malformed");

endmodule

`default_nettype wire
